/* src/htbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_pkg
// Shared constants, codes and control types of the Huffman tree build and
// decode unit.
// ----------------------------------------------------------------------------
package htbd_pkg;

    localparam int MAX_SYMBOLS = 32;
    localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS - 1;
    localparam int LEAF_W      = $clog2(MAX_SYMBOLS);
    localparam int COUNT_W     = $clog2(MAX_SYMBOLS + 1);
    localparam int NODE_W      = $clog2(2 * MAX_SYMBOLS);
    localparam int SYM_W       = 8;
    localparam int LEAF_WT_W   = 16;
    localparam int WEIGHT_W    = 21;
    localparam int CODE_W      = 31;
    localparam int LEN_W       = 5;

    localparam logic [NODE_W-1:0] NO_PARENT = {NODE_W{1'b1}};

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_BUILD  = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    localparam logic [1:0] KIND_CODE   = 2'd0;
    localparam logic [1:0] KIND_SYMBOL = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_FULL    = 2'd1;
    localparam logic [1:0] ERR_NO_TREE = 2'd2;

    localparam int ACT_W = 5;
    localparam logic [ACT_W-1:0] A_NOP        = 5'd0;
    localparam logic [ACT_W-1:0] A_CAPTURE    = 5'd1;
    localparam logic [ACT_W-1:0] A_LOAD       = 5'd2;
    localparam logic [ACT_W-1:0] A_BUILD_START = 5'd3;
    localparam logic [ACT_W-1:0] A_INIT_WR    = 5'd4;
    localparam logic [ACT_W-1:0] A_SCAN       = 5'd5;
    localparam logic [ACT_W-1:0] A_MERGE_A    = 5'd6;
    localparam logic [ACT_W-1:0] A_MERGE_B    = 5'd7;
    localparam logic [ACT_W-1:0] A_WALK_ISSUE = 5'd8;
    localparam logic [ACT_W-1:0] A_WALK_GETF  = 5'd9;
    localparam logic [ACT_W-1:0] A_WALK_RD    = 5'd10;
    localparam logic [ACT_W-1:0] A_WALK_STEP  = 5'd11;
    localparam logic [ACT_W-1:0] A_EMIT_CODE  = 5'd12;
    localparam logic [ACT_W-1:0] A_DEC_RD     = 5'd13;
    localparam logic [ACT_W-1:0] A_DEC_NX     = 5'd14;
    localparam logic [ACT_W-1:0] A_EMIT_SYM   = 5'd15;
    localparam logic [ACT_W-1:0] A_EMIT_EOM   = 5'd16;
    localparam logic [ACT_W-1:0] A_EMIT_ERR1  = 5'd17;
    localparam logic [ACT_W-1:0] A_EMIT_ERR2  = 5'd18;

    typedef struct packed {
        logic [ACT_W-1:0] act;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] in_op;
        logic       built;
        logic       full;
        logic       few_leaves;
        logic       init_end;
        logic       scan_end;
        logic       merge_end;
        logic       walk_done;
        logic       leaf_last;
        logic       dec_leaf;
        logic       out_free;
    } dp_stat_t;

endpackage

/* src/htbd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module htbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/htbd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_datapath
// Node tables, build scan and merge registers, code walk, decode cursor and
// the output register, all driven by action codes from the controller.
// ----------------------------------------------------------------------------
module htbd_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  htbd_pkg::dp_cmd_t              cmd,
    output htbd_pkg::dp_stat_t             stat,
    input  logic [1:0]                     in_op,
    input  logic [htbd_pkg::SYM_W-1:0]     in_symbol,
    input  logic [htbd_pkg::LEAF_WT_W-1:0] in_weight,
    input  logic                           in_bit,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     out_kind,
    output logic [htbd_pkg::SYM_W-1:0]     out_symbol,
    output logic [htbd_pkg::CODE_W-1:0]    out_code,
    output logic [htbd_pkg::LEN_W-1:0]     out_len,
    output logic                           out_incomplete,
    output logic [1:0]                     out_error,
    output logic                           out_last
);
    import htbd_pkg::*;

    logic [1:0]          op_reg, op_next;
    logic [SYM_W-1:0]    sym_in_reg, sym_in_next;
    logic [LEAF_WT_W-1:0] wt_in_reg, wt_in_next;
    logic                bit_reg, bit_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                built_reg, built_next;
    logic [NODE_W-1:0]   cursor_reg, cursor_next;
    logic [NODE_W-1:0]   idx_reg, idx_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [NODE_W-1:0]   b1_reg, b1_next, b2_reg, b2_next;
    logic                b1v_reg, b1v_next, b2v_reg, b2v_next;
    logic [WEIGHT_W-1:0] w1_reg, w1_next, w2_reg, w2_next;
    logic                scan_v_reg, scan_v_next;
    logic [NODE_W-1:0]   scan_j_reg, scan_j_next;
    logic [LEAF_W-1:0]   leaf_reg, leaf_next;
    logic [NODE_W-1:0]   c_reg, c_next, f_reg, f_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEAF_W-1:0]   sym_addr_reg, sym_addr_next;
    logic                ov_reg, ov_next;
    logic [1:0]          okind_reg, okind_next;
    logic [SYM_W-1:0]    osym_reg, osym_next;
    logic [CODE_W-1:0]   ocode_reg, ocode_next;
    logic [LEN_W-1:0]    olen_reg, olen_next;
    logic                oinc_reg, oinc_next;
    logic [1:0]          oerr_reg, oerr_next;
    logic                olast_reg, olast_next;

    logic [NODE_W-1:0]   root;
    logic [COUNT_W-1:0]  eff_count;
    logic [NODE_W-1:0]   leaf_node;
    logic [NODE_W-1:0]   nxt;
    logic [2*NODE_W-1:0] child_wdata, child_rdata;
    logic [NODE_W-1:0]   child_raddr;
    logic                child_we;
    logic [NODE_W-1:0]   par_waddr, par_wdata, par_raddr, par_rdata;
    logic                par_we;
    logic [NODE_W-1:0]   wt_waddr;
    logic [WEIGHT_W-1:0] wt_wdata, wt_rdata;
    logic                wt_we;
    logic                sym_we;
    logic [SYM_W-1:0]    sym_rdata;
    logic                out_free;

    assign root      = NODE_W'({1'b0, count_reg, 1'b0} - 2);
    assign eff_count = built_reg ? '0 : count_reg;
    assign leaf_node = NODE_W'(leaf_reg);
    assign nxt       = bit_reg ? child_rdata[2*NODE_W-1:NODE_W] : child_rdata[NODE_W-1:0];
    assign out_free  = !ov_reg || out_ready;

    assign par_we    = (cmd.act == A_INIT_WR) || (cmd.act == A_MERGE_A)
                       || (cmd.act == A_MERGE_B);
    assign par_waddr = (cmd.act == A_INIT_WR) ? idx_reg :
                       (cmd.act == A_MERGE_A) ? b1_reg : b2_reg;
    assign par_wdata = (cmd.act == A_INIT_WR) ? NO_PARENT : node_reg;
    assign par_raddr = (cmd.act == A_WALK_ISSUE) ? leaf_node :
                       (cmd.act == A_WALK_RD) ? f_reg : idx_reg;

    assign child_we    = (cmd.act == A_MERGE_A);
    assign child_wdata = {b2_reg, b1_reg};
    assign child_raddr = (cmd.act == A_WALK_RD) ? f_reg : cursor_reg;

    assign wt_we    = (cmd.act == A_MERGE_A) || ((cmd.act == A_LOAD) && !stat.full);
    assign wt_waddr = (cmd.act == A_MERGE_A) ? node_reg : NODE_W'(eff_count);
    assign wt_wdata = (cmd.act == A_MERGE_A) ? WEIGHT_W'(w1_reg + w2_reg)
                                             : WEIGHT_W'(wt_in_reg);
    assign sym_we   = (cmd.act == A_LOAD) && !stat.full;

    htbd_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_parent (
        .clk(aclk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );

    htbd_ram #(.WIDTH(2 * NODE_W), .DEPTH(NODE_DEPTH)) u_child (
        .clk(aclk), .we(child_we), .waddr(node_reg), .wdata(child_wdata),
        .raddr(child_raddr), .rdata(child_rdata)
    );

    htbd_ram #(.WIDTH(WEIGHT_W), .DEPTH(NODE_DEPTH)) u_weight (
        .clk(aclk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
        .raddr(idx_reg), .rdata(wt_rdata)
    );

    htbd_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SYMBOLS)) u_symbol (
        .clk(aclk), .we(sym_we), .waddr(LEAF_W'(eff_count)), .wdata(sym_in_reg),
        .raddr(sym_addr_reg), .rdata(sym_rdata)
    );

    always_comb begin
        stat.in_op      = op_reg;
        stat.built      = built_reg;
        stat.full       = !built_reg && (count_reg >= COUNT_W'(MAX_SYMBOLS));
        stat.few_leaves = count_reg < COUNT_W'(2);
        stat.init_end   = idx_reg == root;
        stat.scan_end   = idx_reg == node_reg - NODE_W'(1);
        stat.merge_end  = node_reg == root;
        stat.walk_done  = (f_reg == NO_PARENT) || (len_reg == {LEN_W{1'b1}});
        stat.leaf_last  = COUNT_W'(leaf_reg) + COUNT_W'(1) == count_reg;
        stat.dec_leaf   = nxt < NODE_W'(count_reg);
        stat.out_free   = out_free;
    end

    always_comb begin
        op_next       = op_reg;
        sym_in_next   = sym_in_reg;
        wt_in_next    = wt_in_reg;
        bit_next      = bit_reg;
        count_next    = count_reg;
        built_next    = built_reg;
        cursor_next   = cursor_reg;
        idx_next      = idx_reg;
        node_next     = node_reg;
        b1_next       = b1_reg;
        b2_next       = b2_reg;
        b1v_next      = b1v_reg;
        b2v_next      = b2v_reg;
        w1_next       = w1_reg;
        w2_next       = w2_reg;
        scan_v_next   = (cmd.act == A_SCAN);
        scan_j_next   = idx_reg;
        leaf_next     = leaf_reg;
        c_next        = c_reg;
        f_next        = f_reg;
        code_next     = code_reg;
        len_next      = len_reg;
        sym_addr_next = sym_addr_reg;
        ov_next       = ov_reg && !out_ready;
        okind_next    = okind_reg;
        osym_next     = osym_reg;
        ocode_next    = ocode_reg;
        olen_next     = olen_reg;
        oinc_next     = oinc_reg;
        oerr_next     = oerr_reg;
        olast_next    = olast_reg;

        if (scan_v_reg && (par_rdata == NO_PARENT)) begin
            if (!b1v_reg || (wt_rdata < w1_reg)) begin
                b2_next  = b1_reg;
                w2_next  = w1_reg;
                b2v_next = b1v_reg;
                b1_next  = scan_j_reg;
                w1_next  = wt_rdata;
                b1v_next = 1'b1;
            end else if (!b2v_reg || (wt_rdata < w2_reg)) begin
                b2_next  = scan_j_reg;
                w2_next  = wt_rdata;
                b2v_next = 1'b1;
            end
        end

        case (cmd.act)
            A_CAPTURE: begin
                op_next     = in_op;
                sym_in_next = in_symbol;
                wt_in_next  = in_weight;
                bit_next    = in_bit;
            end
            A_LOAD: begin
                if (!stat.full) begin
                    count_next = eff_count + COUNT_W'(1);
                    built_next = 1'b0;
                end
            end
            A_BUILD_START: begin
                idx_next  = '0;
                node_next = NODE_W'(count_reg);
            end
            A_INIT_WR: begin
                if (stat.init_end) begin
                    idx_next = '0;
                    b1v_next = 1'b0;
                    b2v_next = 1'b0;
                end else begin
                    idx_next = idx_reg + NODE_W'(1);
                end
            end
            A_SCAN: begin
                idx_next = idx_reg + NODE_W'(1);
            end
            A_MERGE_B: begin
                if (stat.merge_end) begin
                    built_next  = 1'b1;
                    cursor_next = root;
                    leaf_next   = '0;
                end else begin
                    node_next = node_reg + NODE_W'(1);
                    idx_next  = '0;
                    b1v_next  = 1'b0;
                    b2v_next  = 1'b0;
                end
            end
            A_WALK_ISSUE: begin
                c_next        = leaf_node;
                code_next     = '0;
                len_next      = '0;
                sym_addr_next = leaf_reg;
            end
            A_WALK_GETF: begin
                f_next = par_rdata;
            end
            A_WALK_STEP: begin
                if (child_rdata[2*NODE_W-1:NODE_W] == c_reg) begin
                    code_next = code_reg | (CODE_W'(1) << len_reg);
                end
                len_next = len_reg + LEN_W'(1);
                c_next   = f_reg;
                f_next   = par_rdata;
            end
            A_EMIT_CODE: begin
                ov_next    = 1'b1;
                okind_next = KIND_CODE;
                osym_next  = sym_rdata;
                ocode_next = code_reg;
                olen_next  = len_reg;
                oinc_next  = 1'b0;
                oerr_next  = ERR_NONE;
                olast_next = stat.leaf_last;
                leaf_next  = leaf_reg + LEAF_W'(1);
            end
            A_DEC_NX: begin
                if (stat.dec_leaf) begin
                    sym_addr_next = LEAF_W'(nxt);
                end else begin
                    cursor_next = nxt;
                end
            end
            A_EMIT_SYM: begin
                ov_next     = 1'b1;
                okind_next  = KIND_SYMBOL;
                osym_next   = sym_rdata;
                ocode_next  = '0;
                olen_next   = '0;
                oinc_next   = 1'b0;
                oerr_next   = ERR_NONE;
                olast_next  = 1'b1;
                cursor_next = root;
            end
            A_EMIT_EOM: begin
                ov_next     = 1'b1;
                okind_next  = KIND_END;
                osym_next   = '0;
                ocode_next  = '0;
                olen_next   = '0;
                oinc_next   = cursor_reg != root;
                oerr_next   = ERR_NONE;
                olast_next  = 1'b1;
                cursor_next = root;
            end
            A_EMIT_ERR1, A_EMIT_ERR2: begin
                ov_next    = 1'b1;
                okind_next = KIND_ERROR;
                osym_next  = '0;
                ocode_next = '0;
                olen_next  = '0;
                oinc_next  = 1'b0;
                oerr_next  = (cmd.act == A_EMIT_ERR1) ? ERR_FULL : ERR_NO_TREE;
                olast_next = 1'b1;
                if (cmd.act == A_EMIT_ERR2) begin
                    built_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            built_reg  <= 1'b0;
            cursor_reg <= '0;
            scan_v_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            count_reg  <= count_next;
            built_reg  <= built_next;
            cursor_reg <= cursor_next;
            scan_v_reg <= scan_v_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        sym_in_reg   <= sym_in_next;
        wt_in_reg    <= wt_in_next;
        bit_reg      <= bit_next;
        idx_reg      <= idx_next;
        node_reg     <= node_next;
        b1_reg       <= b1_next;
        b2_reg       <= b2_next;
        b1v_reg      <= b1v_next;
        b2v_reg      <= b2v_next;
        w1_reg       <= w1_next;
        w2_reg       <= w2_next;
        scan_j_reg   <= scan_j_next;
        leaf_reg     <= leaf_next;
        c_reg        <= c_next;
        f_reg        <= f_next;
        code_reg     <= code_next;
        len_reg      <= len_next;
        sym_addr_reg <= sym_addr_next;
        okind_reg    <= okind_next;
        osym_reg     <= osym_next;
        ocode_reg    <= ocode_next;
        olen_reg     <= olen_next;
        oinc_reg     <= oinc_next;
        oerr_reg     <= oerr_next;
        olast_reg    <= olast_next;
    end

    assign out_valid      = ov_reg;
    assign out_kind       = okind_reg;
    assign out_symbol     = osym_reg;
    assign out_code       = ocode_reg;
    assign out_len        = olen_reg;
    assign out_incomplete = oinc_reg;
    assign out_error      = oerr_reg;
    assign out_last       = olast_reg;

endmodule

/* src/htbd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_ctrl
// Controller state machine: sequences loads, the tree build, the code walk,
// decoding and result emission through action codes to the datapath.
// ----------------------------------------------------------------------------
module htbd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  htbd_pkg::dp_stat_t  stat,
    output htbd_pkg::dp_cmd_t   cmd
);
    import htbd_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_INIT  = 5'd2;
    localparam logic [4:0] S_SCAN  = 5'd3;
    localparam logic [4:0] S_TAIL  = 5'd4;
    localparam logic [4:0] S_MRGA  = 5'd5;
    localparam logic [4:0] S_MRGB  = 5'd6;
    localparam logic [4:0] S_WISS  = 5'd7;
    localparam logic [4:0] S_WGETF = 5'd8;
    localparam logic [4:0] S_WCHK  = 5'd9;
    localparam logic [4:0] S_WSTEP = 5'd10;
    localparam logic [4:0] S_ECODE = 5'd11;
    localparam logic [4:0] S_DRD   = 5'd12;
    localparam logic [4:0] S_DNX   = 5'd13;
    localparam logic [4:0] S_DSYM  = 5'd14;
    localparam logic [4:0] S_DEMIT = 5'd15;
    localparam logic [4:0] S_EOM   = 5'd16;
    localparam logic [4:0] S_ERR1  = 5'd17;
    localparam logic [4:0] S_ERR2  = 5'd18;

    logic [4:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.act    = A_NOP;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.act    = A_CAPTURE;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (stat.in_op)
                    OP_LOAD: begin
                        if (stat.full) begin
                            state_next = S_ERR1;
                        end else begin
                            cmd.act    = A_LOAD;
                            state_next = S_IDLE;
                        end
                    end
                    OP_BUILD: begin
                        if (stat.few_leaves) begin
                            state_next = S_ERR2;
                        end else begin
                            cmd.act    = A_BUILD_START;
                            state_next = S_INIT;
                        end
                    end
                    OP_DECODE: begin
                        state_next = stat.built ? S_DRD : S_ERR2;
                    end
                    default: begin
                        state_next = stat.built ? S_EOM : S_ERR2;
                    end
                endcase
            end
            S_INIT: begin
                cmd.act = A_INIT_WR;
                if (stat.init_end) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.act = A_SCAN;
                if (stat.scan_end) begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL: begin
                state_next = S_MRGA;
            end
            S_MRGA: begin
                cmd.act    = A_MERGE_A;
                state_next = S_MRGB;
            end
            S_MRGB: begin
                cmd.act    = A_MERGE_B;
                state_next = stat.merge_end ? S_WISS : S_SCAN;
            end
            S_WISS: begin
                cmd.act    = A_WALK_ISSUE;
                state_next = S_WGETF;
            end
            S_WGETF: begin
                cmd.act    = A_WALK_GETF;
                state_next = S_WCHK;
            end
            S_WCHK: begin
                if (stat.walk_done) begin
                    state_next = S_ECODE;
                end else begin
                    cmd.act    = A_WALK_RD;
                    state_next = S_WSTEP;
                end
            end
            S_WSTEP: begin
                cmd.act    = A_WALK_STEP;
                state_next = S_WCHK;
            end
            S_ECODE: begin
                if (stat.out_free) begin
                    cmd.act    = A_EMIT_CODE;
                    state_next = stat.leaf_last ? S_IDLE : S_WISS;
                end
            end
            S_DRD: begin
                cmd.act    = A_DEC_RD;
                state_next = S_DNX;
            end
            S_DNX: begin
                cmd.act    = A_DEC_NX;
                state_next = stat.dec_leaf ? S_DSYM : S_IDLE;
            end
            S_DSYM: begin
                state_next = S_DEMIT;
            end
            S_DEMIT: begin
                if (stat.out_free) begin
                    cmd.act    = A_EMIT_SYM;
                    state_next = S_IDLE;
                end
            end
            S_EOM: begin
                if (stat.out_free) begin
                    cmd.act    = A_EMIT_EOM;
                    state_next = S_IDLE;
                end
            end
            S_ERR1: begin
                if (stat.out_free) begin
                    cmd.act    = A_EMIT_ERR1;
                    state_next = S_IDLE;
                end
            end
            S_ERR2: begin
                if (stat.out_free) begin
                    cmd.act    = A_EMIT_ERR2;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/huffman_tree_build_and_decode_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_build_and_decode_unit
// Huffman tree builder with code listing and bit-serial decoder.
// ----------------------------------------------------------------------------
// Code results, decoded symbols, end of message and errors wait for the result
// register to empty before they are issued. A build with n leaves walks the
// node tables held in single-read-port RAMs: it marks 2n-1 nodes parentless,
// then for the merge that creates node i it reads each candidate node in turn,
// then for each leaf it walks up the tree, one level of its code per step. A new
// transaction is taken once the previous one has finished its work, even while
// its last result still waits in the output register.
module huffman_tree_build_and_decode_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // symbol[7:0], weight[23:8], coded_bit[24], zero
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_symbol[7:0], code_bits[38:8],
                                   // code_length[43:39], incomplete[44],
                                   // error_code[46:45], zero
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);
    import htbd_pkg::*;

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [SYM_W-1:0] out_symbol;
    logic [CODE_W-1:0] out_code;
    logic [LEN_W-1:0] out_len;
    logic             out_incomplete;
    logic [1:0]       out_error;

    htbd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .stat(stat), .cmd(cmd)
    );

    htbd_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_op(s_tuser), .in_symbol(s_tdata[7:0]), .in_weight(s_tdata[23:8]),
        .in_bit(s_tdata[24]),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_kind(m_tuser),
        .out_symbol(out_symbol), .out_code(out_code), .out_len(out_len),
        .out_incomplete(out_incomplete), .out_error(out_error), .out_last(m_tlast)
    );

    assign m_tdata = {1'b0, out_error, out_incomplete, out_len, out_code, out_symbol};

endmodule

/* src/htbd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htbd_checker
// Port-level checks on the result stream of the Huffman unit.
// ----------------------------------------------------------------------------
module htbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import htbd_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result withdrawn while stalled.");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("Result changed while stalled.");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_CODE) |-> m_tlast)
        else $error("Single result transaction without last.");

    a_error_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ERROR) |-> (m_tdata[46:45] != ERR_NONE))
        else $error("Error result without an error code.");

    a_code_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_CODE) |-> (m_tdata[46:44] == 3'b000)
            && (m_tdata[43:39] != 5'd0))
        else $error("Code result with bad status or empty code.");

endmodule

bind huffman_tree_build_and_decode_unit htbd_checker u_htbd_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
